[sv/u8u16_pkg.sv]
// Shared types, constants and functions of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] UNIT_REPLACE = 16'hFFFD;
	localparam logic [15:0] HI_SURR_LO   = 16'hD800;
	localparam logic [15:0] HI_SURR_HI   = 16'hDBFF;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [31:0] BMP_MAX      = 32'h0000FFFF;
	localparam logic [31:0] CODE_MAX     = 32'h0010FFFF;
	localparam logic [31:0] SUPP_BASE    = 32'h00010000;

	localparam logic KIND_UNIT  = 1'b0;
	localparam logic KIND_TRUNC = 1'b1;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        kind;
		logic        run_last;
		logic        stream_end;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} res_pair_t;

	function automatic logic [2:0] trail_count(input logic [7:0] b);
		logic [2:0] t;
		if (b < 8'hC0)      t = 3'd0;
		else if (b < 8'hE0) t = 3'd1;
		else if (b < 8'hF0) t = 3'd2;
		else if (b < 8'hF8) t = 3'd3;
		else if (b < 8'hFC) t = 3'd4;
		else                t = 3'd5;
		return t;
	endfunction

	function automatic logic [31:0] legacy_offset(input logic [2:0] t);
		logic [31:0] o;
		case (t)
			3'd1: o = 32'h00003080;
			3'd2: o = 32'h000E2080;
			3'd3: o = 32'h03C82080;
			3'd4: o = 32'hFA082080;
			3'd5: o = 32'h82082080;
			default: o = 32'h00000000;
		endcase
		return o;
	endfunction

endpackage

[sv/utf8_to_utf16_transcoder_unit.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Input channel byte_*: one UTF-8 byte per transfer, last_byte marks the end
// of a string. Output channel unit_*: one UTF-16 code unit per transfer, with
// kind set on the single error result of a string that ends inside a sequence.
// A transfer happens on a rising edge with valid high and stall low.
// A byte is taken into an input register, decoded from there once the queue
// has room for two results, and its zero, one or two results are written into
// a four-entry result queue. A byte's first result is offered once it is in
// the queue; the low half of a surrogate pair follows it in the next entry.
// One byte per cycle is taken while the queue has room for two results, so
// the sustained rate is one byte per cycle, bounded by one result per cycle
// on the output side.
// When the receiver stalls, the offered result holds and the queue fills;
// byte_stall rises while a byte waits in the input register and fewer than two entries are free.
// Reset clears the sequence state, the input register's valid flag and the queue pointers and count.
module utf8_to_utf16_transcoder_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  u8u16_pkg::in_item_t   byte_data,
	output logic                  unit_valid,
	input  logic                  unit_stall,
	output u8u16_pkg::out_item_t  unit_data
);
	import u8u16_pkg::*;

	logic       valid_s1;
	in_item_t   data_s1;
	logic       advance;
	logic       take;
	res_pair_t  res;

	out_item_t        fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       push_n;
	logic             pop;

	assign advance    = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;
	assign push_n     = advance ? res.count : 2'd0;
	assign unit_valid = (count_q != '0);
	assign unit_data  = fifo_q[head_q];
	assign pop        = unit_valid && !unit_stall;

	u8u16_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (data_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[tail_q] <= res.first;
		end
		if (push_n == 2'd2) begin
			fifo_q[tail_q + PTR_W'(1)] <= res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push_n);
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

[sv/u8u16_decode.sv]
// Sequence state and per-byte result computation of the transcoder.
module u8u16_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  u8u16_pkg::in_item_t item,
	output u8u16_pkg::res_pair_t res
);
	import u8u16_pkg::*;

	logic [31:0] acc_q;
	logic [2:0]  left_q;
	logic [2:0]  trail_q;

	logic        lead;
	logic [2:0]  trail_n;
	logic [2:0]  left_n;
	logic [31:0] acc_n;
	logic        done;
	logic [31:0] ch;
	logic [19:0] supp;
	logic        last;

	always_comb begin
		last    = item.last_byte;
		lead    = (left_q == 3'd0);
		trail_n = lead ? trail_count(item.byte_in) : trail_q;
		left_n  = lead ? trail_count(item.byte_in) : left_q - 3'd1;
		acc_n   = lead ? {24'd0, item.byte_in}
		               : {acc_q[25:0], 6'd0} + {24'd0, item.byte_in};
		done    = (left_n == 3'd0);
		ch      = acc_n - legacy_offset(trail_n);
		supp    = ch[19:0] - SUPP_BASE[19:0];

		res        = '0;
		res.count  = 2'd0;
		if (done) begin
			res.count = 2'd1;
			if (ch <= BMP_MAX) begin
				if (ch[15:0] >= HI_SURR_LO && ch[15:0] <= HI_SURR_HI) begin
					res.first.code_unit = UNIT_REPLACE;
				end else begin
					res.first.code_unit = ch[15:0];
				end
			end else if (ch > CODE_MAX) begin
				res.first.code_unit = UNIT_REPLACE;
			end else begin
				res.count            = 2'd2;
				res.first.code_unit  = HI_SURR_LO + {6'd0, supp[19:10]};
				res.second.code_unit = LO_SURR_BASE + {6'd0, supp[9:0]};
			end
			res.first.kind  = KIND_UNIT;
			res.second.kind = KIND_UNIT;
		end else if (last) begin
			res.count           = 2'd1;
			res.first.code_unit = 16'd0;
			res.first.kind      = KIND_TRUNC;
		end
		res.first.run_last    = (res.count == 2'd1);
		res.first.stream_end  = last && (res.count == 2'd1);
		res.second.run_last   = 1'b1;
		res.second.stream_end = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			left_q  <= '0;
			trail_q <= '0;
		end else if (en) begin
			acc_q   <= (done || last) ? 32'd0 : acc_n;
			trail_q <= (done || last) ? 3'd0 : trail_n;
			left_q  <= last ? 3'd0 : left_n;
		end
	end

endmodule

[sv/u8u16_checker.sv]
// Port-level checks of the transcoder and their binding to the top level.
module u8u16_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input u8u16_pkg::in_item_t  byte_data,
	input logic                 unit_valid,
	input logic                 unit_stall,
	input u8u16_pkg::out_item_t unit_data
);
	import u8u16_pkg::*;

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_stall) |=> (byte_valid && $stable(byte_data)))
		else $error("stalled byte changed");

	a_trunc_form: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && unit_data.kind == KIND_TRUNC) |->
		(unit_data.code_unit == 16'd0 && unit_data.run_last && unit_data.stream_end))
		else $error("error result with bad fields");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && unit_data.stream_end) |-> unit_data.run_last)
		else $error("stream end without run end");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && !unit_stall && unit_data.kind == KIND_UNIT &&
		 unit_data.code_unit[15:10] == 6'b110110) |=>
		(unit_valid && unit_data.code_unit[15:10] == 6'b110111))
		else $error("high surrogate not followed by low surrogate");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && unit_stall) |=> (unit_valid && $stable(unit_data)))
		else $error("stalled result changed");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.unit_valid (unit_valid),
	.unit_stall (unit_stall),
	.unit_data  (unit_data)
);

[test/tb_utf8_to_utf16_transcoder_unit.sv]
// Self-checking testbench for the UTF-8 to UTF-16 transcoder top level.
module tb_utf8_to_utf16_transcoder_unit;

	import u8u16_pkg::*;

	localparam int PHASE_BYTES  = 425;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DIR_N        = 25;

	localparam logic [31:0] SEQ_OFFSET [0:5] = '{
		32'h00000000, 32'h00003080, 32'h000E2080,
		32'h03C82080, 32'hFA082080, 32'h82082080
	};

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
		{8'h00, 1'b1, 1'b1, 16'h0000, KIND_UNIT,  1'b1, 1'b1},
		{8'h7F, 1'b0, 1'b1, 16'h007F, KIND_UNIT,  1'b1, 1'b0},
		{8'h80, 1'b0, 1'b1, 16'h0080, KIND_UNIT,  1'b1, 1'b0},
		{8'hFF, 1'b1, 1'b1, 16'h0000, KIND_TRUNC, 1'b1, 1'b1},
		{8'hC3, 1'b0, 1'b0, 19'd0},
		{8'hA9, 1'b0, 1'b0, 19'd0},
		{8'hED, 1'b0, 1'b0, 19'd0},
		{8'hA0, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'hED, 1'b0, 1'b0, 19'd0},
		{8'hB0, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'hF0, 1'b0, 1'b0, 19'd0},
		{8'h9F, 1'b0, 1'b0, 19'd0},
		{8'h98, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'hF4, 1'b0, 1'b0, 19'd0},
		{8'h90, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'hF8, 1'b0, 1'b0, 19'd0},
		{8'h88, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b0, 1'b0, 19'd0},
		{8'h80, 1'b1, 1'b0, 19'd0}
	};

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data  = '0;
	logic      unit_valid;
	logic      unit_stall = 1'b0;
	out_item_t unit_data;

	logic [31:0] seq_acc   = '0;
	logic [2:0]  seq_left  = '0;
	logic [2:0]  seq_trail = '0;

	out_item_t pending_units [$];
	out_item_t want_unit;

	int idle_pct      = 0;
	int stall_pct     = 0;
	int errors        = 0;
	int cycle_cnt     = 0;
	int bytes_sent    = 0;
	int strings_sent  = 0;
	int units_checked = 0;
	int trunc_seen    = 0;
	int pairs_seen    = 0;

	utf8_to_utf16_transcoder_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	function automatic logic [2:0] lead_trail(input logic [7:0] b);
		int ones;
		ones = 0;
		while (ones < 8 && b[7 - ones])
			ones++;
		if (ones < 2)
			return 3'd0;
		if (ones > 6)
			return 3'd5;
		return 3'(ones - 1);
	endfunction

	task automatic decode_byte(input in_item_t it, output int n,
			output out_item_t r0, output out_item_t r1);
		logic [31:0] cp;
		out_item_t   r [2];
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (seq_left == 3'd0) begin
			seq_trail = lead_trail(it.byte_in);
			seq_left  = seq_trail;
			seq_acc   = {24'd0, it.byte_in};
		end else begin
			seq_acc  = (seq_acc << 6) + {24'd0, it.byte_in};
			seq_left = seq_left - 3'd1;
		end
		if (seq_left == 3'd0) begin
			cp = seq_acc - SEQ_OFFSET[seq_trail];
			if (cp <= BMP_MAX) begin
				r[0].code_unit = (cp[15:0] >= HI_SURR_LO && cp[15:0] <= HI_SURR_HI) ?
					UNIT_REPLACE : cp[15:0];
				n = 1;
			end else if (cp > CODE_MAX) begin
				r[0].code_unit = UNIT_REPLACE;
				n = 1;
			end else begin
				cp = cp - SUPP_BASE;
				r[0].code_unit = HI_SURR_LO + {6'd0, cp[19:10]};
				r[1].code_unit = LO_SURR_BASE + {6'd0, cp[9:0]};
				n = 2;
			end
			seq_acc   = '0;
			seq_trail = '0;
		end else if (it.last_byte) begin
			r[0].kind = KIND_TRUNC;
			n = 1;
		end
		if (n > 0)
			r[n - 1].run_last = 1'b1;
		if (it.last_byte) begin
			if (n > 0)
				r[n - 1].stream_end = 1'b1;
			seq_acc   = '0;
			seq_left  = '0;
			seq_trail = '0;
		end
		r0 = r[0];
		r1 = r[1];
	endtask

	task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
		int        n;
		out_item_t r0;
		out_item_t r1;
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		decode_byte(it, n, r0, r1);
		if (typed) begin
			pending_units.push_back(want);
		end else begin
			if (n > 0)
				pending_units.push_back(r0);
			if (n > 1) begin
				pending_units.push_back(r1);
				pairs_seen++;
			end
		end
		bytes_sent++;
		if (it.last_byte)
			strings_sent++;
	endtask

	task automatic send_string();
		int         nseq;
		int         roll;
		int         len;
		int         trail;
		bit         final_seq;
		logic [7:0] b;
		in_item_t   it;
		nseq = $urandom_range(1, 6);
		for (int s = 0; s < nseq; s++) begin
			final_seq = (s == nseq - 1);
			if ($urandom_range(99) < 5) begin
				// stray byte with a random end mark
				it.byte_in   = 8'($urandom);
				it.last_byte = 1'($urandom_range(1));
				send_byte(it, 1'b0, '0);
				continue;
			end
			roll = $urandom_range(99);
			if (roll < 10)
				b = 8'($urandom);
			else if (roll < 35)
				b = 8'($urandom_range(8'h00, 8'h7F));
			else if (roll < 50)
				b = 8'($urandom_range(8'hC0, 8'hDF));
			else if (roll < 68)
				b = ($urandom_range(3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
			else if (roll < 86)
				b = ($urandom_range(3) == 0) ? 8'hF4 : 8'($urandom_range(8'hF0, 8'hF7));
			else if (roll < 93)
				b = 8'($urandom_range(8'hF8, 8'hFB));
			else
				b = 8'($urandom_range(8'hFC, 8'hFF));
			trail = lead_trail(b);
			len = trail + 1;
			if (final_seq && trail > 0 && $urandom_range(99) < 12)
				len = $urandom_range(1, trail);
			for (int k = 0; k < len; k++) begin
				if (k > 0)
					b = ($urandom_range(9) == 0) ? 8'($urandom) :
						8'($urandom_range(8'h80, 8'hBF));
				it.byte_in   = b;
				it.last_byte = final_seq && (k == len - 1);
				send_byte(it, 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && unit_valid && !unit_stall) begin
			if (pending_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer unit=%h kind=%b run_last=%b stream_end=%b",
					$time, unit_data.code_unit, unit_data.kind, unit_data.run_last,
					unit_data.stream_end);
			end else begin
				want_unit = pending_units.pop_front();
				if (unit_data.code_unit !== want_unit.code_unit ||
						unit_data.kind !== want_unit.kind ||
						unit_data.run_last !== want_unit.run_last ||
						unit_data.stream_end !== want_unit.stream_end) begin
					errors++;
					$display("%0t: mismatch expected unit=%h kind=%b run_last=%b stream_end=%b",
						$time, want_unit.code_unit, want_unit.kind, want_unit.run_last,
						want_unit.stream_end);
					$display("%0t:          actual   unit=%h kind=%b run_last=%b stream_end=%b",
						$time, unit_data.code_unit, unit_data.kind, unit_data.run_last,
						unit_data.stream_end);
				end
				units_checked++;
				if (unit_data.kind == KIND_TRUNC)
					trunc_seen++;
			end
		end
		unit_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++)
			send_byte(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 57; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 57; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_string();
		end
		byte_valid <= 1'b0;
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d bytes in %0d strings over four idle/stall mixes.",
			bytes_sent, strings_sent);
		$display("Checked %0d code units, %0d surrogate pairs, %0d truncated strings.",
			units_checked, pairs_seen, trunc_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/utf8_to_utf16_transcoder_unit.sv
sv/u8u16_checker.sv
test/tb_utf8_to_utf16_transcoder_unit.sv
